// File: rtl/lprd_pkg.sv
// ----------------------------------------------------------------------------
// lprd_pkg
// Types and constants shared by the record deframer front, queue and back.
// ----------------------------------------------------------------------------
package lprd_pkg;

  localparam int unsigned HdrBytes = 4;
  localparam int unsigned OfsW     = 48;

  localparam logic KindByte  = 1'b0;
  localparam logic KindEvent = 1'b1;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_ZERO_LEN = 3'd3,
    ST_TRUNC    = 3'd4,
    ST_END      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_LAST  = 2'd1,
    OP_EVENT = 2'd2
  } op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic            kind;
    logic [7:0]      payload_byte;
    logic            last_of_record;
    logic [2:0]      status;
    logic [OfsW-1:0] record_offset;
  } out_item_t;

  typedef struct packed {
    op_e             op;
    logic            first;
    logic [7:0]      data;
    status_e         status;
    logic [OfsW-1:0] offset;
    logic [31:0]     exp_crc;
  } qent_t;

endpackage

// File: rtl/lprd_front.sv
// ----------------------------------------------------------------------------
// lprd_front
// Parses record headers, tracks stream offsets and classifies each beat.
// ----------------------------------------------------------------------------
module lprd_front #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  lprd_pkg::in_item_t in_data_i,
  output logic               push_o,
  output lprd_pkg::qent_t    ent_o
);
  import lprd_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN = 3'b001,
    PH_CRC = 3'b010,
    PH_PAY = 3'b100
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [31:0]            cnt_q, cnt_d;
  logic [31:0]            len_q, len_d;
  logic [31:0]            exp_q, exp_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [63:0]            pos_ext, start_ext;
  logic [OfsW-1:0]        pos_ofs, start_ofs;
  logic [31:0]            len_next;
  logic                   hdr_done;

  assign pos_ext   = 64'(pos_q);
  assign start_ext = 64'(start_q);
  assign pos_ofs   = pos_ext[OfsW-1:0];
  assign start_ofs = start_ext[OfsW-1:0];
  assign len_next  = {len_q[23:0], in_data_i.data_byte};
  assign hdr_done  = (cnt_q == 32'(HdrBytes - 1));

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    exp_d       = exp_q;
    pos_d       = pos_q;
    start_d     = start_q;
    push_o      = 1'b0;
    ent_o.op      = OP_EVENT;
    ent_o.first   = (cnt_q == 32'd0);
    ent_o.data    = in_data_i.data_byte;
    ent_o.status  = ST_BUSY;
    ent_o.offset  = start_ofs;
    ent_o.exp_crc = exp_q;
    if (acc_i) begin
      if (in_data_i.end_of_data) begin
        push_o = 1'b1;
        if (phase_q == PH_LEN && cnt_q == 32'd0) begin
          ent_o.status = ST_END;
          ent_o.offset = pos_ofs;
        end else begin
          ent_o.status = ST_TRUNC;
        end
        phase_d = PH_LEN;
        cnt_d   = '0;
        len_d   = '0;
        exp_d   = '0;
      end else begin
        pos_d = pos_q + OFFSET_BITS'(1);
        case (phase_q)
          PH_CRC: begin
            exp_d = {exp_q[23:0], in_data_i.data_byte};
            if (hdr_done) begin
              cnt_d   = '0;
              phase_d = PH_PAY;
            end else begin
              cnt_d = cnt_q + 32'd1;
            end
          end
          PH_PAY: begin
            push_o = 1'b1;
            if (cnt_q + 32'd1 == len_q) begin
              ent_o.op = OP_LAST;
              phase_d  = PH_LEN;
              cnt_d    = '0;
              len_d    = '0;
              exp_d    = '0;
            end else begin
              ent_o.op = OP_DATA;
              cnt_d    = cnt_q + 32'd1;
            end
          end
          default: begin
            if (cnt_q == 32'd0) begin
              start_d = pos_q;
            end
            len_d = len_next;
            if (hdr_done) begin
              cnt_d = '0;
              if (len_next == 32'd0) begin
                push_o       = 1'b1;
                ent_o.status = ST_ZERO_LEN;
                phase_d      = PH_LEN;
                len_d        = '0;
                exp_d        = '0;
              end else begin
                phase_d = PH_CRC;
              end
            end else begin
              cnt_d   = cnt_q + 32'd1;
              phase_d = PH_LEN;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      cnt_q   <= '0;
      len_q   <= '0;
      exp_q   <= '0;
      pos_q   <= '0;
      start_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      exp_q   <= exp_d;
      pos_q   <= pos_d;
      start_q <= start_d;
    end
  end

endmodule

// File: rtl/lprd_queue.sv
// ----------------------------------------------------------------------------
// lprd_queue
// Two-entry queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module lprd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lprd_pkg::qent_t ent_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output lprd_pkg::qent_t ent_o
);
  import lprd_pkg::*;

  qent_t       slot_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign ent_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

// File: rtl/lprd_back.sv
// ----------------------------------------------------------------------------
// lprd_back
// Runs the payload CRC-32, decides record status and holds the result beat.
// ----------------------------------------------------------------------------
module lprd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  lprd_pkg::qent_t     ent_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lprd_pkg::out_item_t out_data_o
);
  import lprd_pkg::*;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic [31:0] crc_q;
  logic [31:0] crc_in, crc_new;
  logic        crc_good;

  assign pop_o    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign crc_in   = ent_i.first ? 32'hFFFF_FFFF : crc_q;
  assign crc_new  = crc_byte(crc_in, ent_i.data);
  assign crc_good = (ent_i.exp_crc == 32'd0) || (~crc_new == ent_i.exp_crc);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      out_valid_d          = 1'b1;
      out_d.record_offset  = ent_i.offset;
      case (ent_i.op)
        OP_DATA: begin
          out_d.kind           = KindByte;
          out_d.payload_byte   = ent_i.data;
          out_d.last_of_record = 1'b0;
          out_d.status         = ST_BUSY;
        end
        OP_LAST: begin
          out_d.kind           = KindByte;
          out_d.payload_byte   = ent_i.data;
          out_d.last_of_record = 1'b1;
          out_d.status         = crc_good ? ST_OK : ST_CRC_ERR;
        end
        default: begin
          out_d.kind           = KindEvent;
          out_d.payload_byte   = 8'd0;
          out_d.last_of_record = 1'b0;
          out_d.status         = ent_i.status;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (pop_o && ent_i.op != OP_EVENT) begin
      crc_q <= crc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_event_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KindEvent) |->
      (out_q.payload_byte == 8'd0 && !out_q.last_of_record))
    else $error("event beat carries payload");

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last_of_record) |->
      (out_q.status == ST_OK || out_q.status == ST_CRC_ERR))
    else $error("last byte without final status");

endmodule

// File: rtl/length_prefixed_record_deframer_crc32_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer_crc32_core
// Deframes length-prefixed records and checks each payload's CRC-32.
//
// A stream byte or end-of-data marker is taken per cycle unless the queue is full.
// Each record is a 4-byte big-endian length, a 4-byte big-endian zlib
// CRC-32 (zero skips the check) and the payload. Payload bytes leave one
// per beat tagged with the record's header offset; the last byte carries
// ok or CRC mismatch. Zero length, truncation and clean end are event-only
// beats. On the way to a result, the header parser registers into a
// two-entry queue, and the CRC byte update with the status compare
// registers into the output stage. Header bytes give no beat.
// ----------------------------------------------------------------------------
module length_prefixed_record_deframer_crc32_core #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lprd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lprd_pkg::out_item_t out_data_o
);
  import lprd_pkg::*;

  logic  acc;
  logic  push;
  logic  full;
  logic  q_valid;
  logic  pop;
  qent_t ent_in;
  qent_t ent_out;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  lprd_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .in_data_i (in_data_i),
    .push_o    (push),
    .ent_o     (ent_in)
  );

  lprd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .ent_o   (ent_out)
  );

  lprd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .ent_i       (ent_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: test/tb_length_prefixed_record_deframer_crc32_core.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_record_deframer_crc32_core
// Self-checking bench for the length-prefixed record deframer with CRC-32.
//
// Drives a byte stream of records into the core: a few hand-picked records
// first, then random traffic that is mostly well-formed records with random
// payloads and checksums (good, skipped and corrupted), mixed with zero-length
// headers, end markers, truncated records and noise. A scoreboard parses the
// same stream, computes every expected beat and compares each output beat
// field by field. Traffic runs in four phases of sender gaps and receiver
// stalls; a watchdog ends the run if the handshakes stop moving.
// ----------------------------------------------------------------------------
module tb_length_prefixed_record_deframer_crc32_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lprd_pkg::*;

  localparam int unsigned BeatsPerPhase = 500;
  localparam int unsigned QuietLimit    = 5000;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_CRC,
    PH_BODY
  } parse_phase_e;

  typedef enum {
    CRC_GOOD,
    CRC_NONE,
    CRC_BAD
  } crc_mode_e;

  class record_scoreboard;
    out_item_t       expected_q[$];
    parse_phase_e    phase;
    logic [31:0]     hdr_count;
    logic [31:0]     rec_len;
    logic [31:0]     rec_crc;
    logic [31:0]     body_crc;
    logic [OfsW-1:0] stream_pos;
    logic [OfsW-1:0] rec_start;
    int unsigned     failures;
    int unsigned     n_bytes;
    int unsigned     n_ok;
    int unsigned     n_crc_err;
    int unsigned     n_zero_len;
    int unsigned     n_trunc;
    int unsigned     n_end;

    function new();
      stream_pos = '0;
      rec_start  = '0;
      failures   = 0;
      n_bytes    = 0;
      n_ok       = 0;
      n_crc_err  = 0;
      n_zero_len = 0;
      n_trunc    = 0;
      n_end      = 0;
      restart();
    endfunction

    static function logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
        r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
      end
      return r;
    endfunction

    function void restart();
      phase     = PH_LEN;
      hdr_count = '0;
      rec_len   = '0;
      rec_crc   = '0;
      body_crc  = '1;
    endfunction

    function void note_input(in_item_t beat);
      out_item_t       r;
      logic [OfsW-1:0] pos;
      r   = '0;
      pos = stream_pos;
      if (beat.end_of_data) begin
        r.kind = KindEvent;
        if (phase == PH_LEN && hdr_count == 0) begin
          r.status        = ST_END;
          r.record_offset = pos;
        end else begin
          r.status        = ST_TRUNC;
          r.record_offset = rec_start;
        end
        expected_q.push_back(r);
        restart();
      end else begin
        stream_pos = pos + OfsW'(1);
        case (phase)
          PH_LEN: begin
            if (hdr_count == 0) rec_start = pos;
            rec_len = {rec_len[23:0], beat.data_byte};
            hdr_count++;
            if (hdr_count == HdrBytes) begin
              hdr_count = '0;
              if (rec_len == 0) begin
                r.kind          = KindEvent;
                r.status        = ST_ZERO_LEN;
                r.record_offset = rec_start;
                expected_q.push_back(r);
                restart();
              end else begin
                phase = PH_CRC;
              end
            end
          end
          PH_CRC: begin
            rec_crc = {rec_crc[23:0], beat.data_byte};
            hdr_count++;
            if (hdr_count == HdrBytes) begin
              hdr_count = '0;
              body_crc  = '1;
              phase     = PH_BODY;
            end
          end
          default: begin
            body_crc = crc32_step(body_crc, beat.data_byte);
            hdr_count++;
            r.kind          = KindByte;
            r.payload_byte  = beat.data_byte;
            r.record_offset = rec_start;
            if (hdr_count == rec_len) begin
              r.last_of_record = 1'b1;
              r.status = (rec_crc == 0 || ~body_crc == rec_crc) ? ST_OK : ST_CRC_ERR;
              expected_q.push_back(r);
              restart();
            end else begin
              r.status = ST_BUSY;
              expected_q.push_back(r);
            end
          end
        endcase
      end
    endfunction

    function void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        failures++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $error("output beat with nothing expected: %h", got);
        failures++;
        return;
      end
      exp_r = expected_q.pop_front();
      check_field("kind", 64'(exp_r.kind), 64'(got.kind));
      check_field("payload_byte", 64'(exp_r.payload_byte), 64'(got.payload_byte));
      check_field("last_of_record", 64'(exp_r.last_of_record), 64'(got.last_of_record));
      check_field("status", 64'(exp_r.status), 64'(got.status));
      check_field("record_offset", 64'(exp_r.record_offset), 64'(got.record_offset));
      if (got.kind == KindByte) n_bytes++;
      case (got.status)
        ST_OK:       n_ok++;
        ST_CRC_ERR:  n_crc_err++;
        ST_ZERO_LEN: n_zero_len++;
        ST_TRUNC:    n_trunc++;
        ST_END:      n_end++;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned beats_sent   = 0;
  int unsigned quiet_cycles = 0;

  record_scoreboard sb;

  always #10 clk_i = ~clk_i;

  length_prefixed_record_deframer_crc32_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("handshakes stalled for %0d cycles", QuietLimit);
    $display("FAIL length_prefixed_record_deframer_crc32_core");
    $finish;
  end

  task automatic send_beat(in_item_t beat);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    in_item_t beat;
    beat.data_byte   = b;
    beat.end_of_data = 1'b0;
    send_beat(beat);
  endtask

  task automatic send_eod();
    in_item_t beat;
    beat.data_byte   = 8'($urandom);
    beat.end_of_data = 1'b1;
    send_beat(beat);
  endtask

  task automatic send_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_record(int unsigned len, crc_mode_e mode);
    logic [7:0]  body[$];
    logic [31:0] c;
    logic [7:0]  b;
    c = '1;
    repeat (len) begin
      b = 8'($urandom);
      body.push_back(b);
      c = record_scoreboard::crc32_step(c, b);
    end
    c = ~c;
    case (mode)
      CRC_NONE: c = '0;
      CRC_BAD:  c = c ^ (32'h1 << $urandom_range(31));
      default: ;
    endcase
    send_word(len);
    send_word(c);
    foreach (body[i]) send_byte(body[i]);
  endtask

  task automatic send_truncated();
    logic [31:0] len;
    logic [31:0] crc;
    int unsigned cut;
    len = $urandom;
    if (len < 16) len = len + 16;
    crc = $urandom;
    cut = $urandom_range(1, 16);
    for (int unsigned i = 0; i < cut; i++) begin
      if (i < 4) begin
        send_byte(len[8*(3-i) +: 8]);
      end else if (i < 8) begin
        send_byte(crc[8*(7-i) +: 8]);
      end else begin
        send_byte(8'($urandom));
      end
    end
    send_eod();
  endtask

  task automatic random_traffic(int unsigned target);
    int unsigned pick;
    int unsigned mode_pick;
    int unsigned len;
    crc_mode_e   mode;
    while (beats_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        mode_pick = $urandom_range(99);
        mode = (mode_pick < 60) ? CRC_GOOD : (mode_pick < 80) ? CRC_NONE : CRC_BAD;
        send_record(len, mode);
      end else if (pick < 73) begin
        send_word(32'h0);
      end else if (pick < 82) begin
        send_eod();
      end else if (pick < 93) begin
        send_truncated();
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        send_eod();
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(32'h0);
    send_eod();
    send_word(32'h1);
    send_word(~record_scoreboard::crc32_step(32'hFFFF_FFFF, 8'hFF));
    send_byte(8'hFF);
    send_word(32'h1);
    send_word(32'h0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_eod();

    random_traffic(BeatsPerPhase);
    drain();

    idle_pct = 59;
    random_traffic(2 * BeatsPerPhase);
    drain();

    idle_pct  = 0;
    stall_pct = 59;
    random_traffic(3 * BeatsPerPhase);
    drain();

    idle_pct  = 21;
    stall_pct = 21;
    random_traffic(4 * BeatsPerPhase);
    drain();
    repeat (4) @(posedge clk_i);

    $display("Streamed %0d input beats over four flow-control phases, %0d payload beats out.",
             beats_sent, sb.n_bytes);
    $display("Records ok %0d, crc mismatch %0d, zero length %0d, truncated %0d, clean end %0d.",
             sb.n_ok, sb.n_crc_err, sb.n_zero_len, sb.n_trunc, sb.n_end);
    if (sb.failures == 0) begin
      $display("PASS length_prefixed_record_deframer_crc32_core");
    end else begin
      $display("FAIL length_prefixed_record_deframer_crc32_core");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lprd_pkg.sv
rtl/lprd_front.sv
rtl/lprd_queue.sv
rtl/lprd_back.sv
rtl/length_prefixed_record_deframer_crc32_core.sv
test/tb_length_prefixed_record_deframer_crc32_core.sv
